// File: sv/stack_with_value_removal_core_assert.svh
// Assertion macros used by the stack controller.
`ifndef STACK_WITH_VALUE_REMOVAL_CORE_ASSERT_SVH
`define STACK_WITH_VALUE_REMOVAL_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// Property that must hold at every clock edge out of reset.
`define SWR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Condition in one cycle implies a condition in the next cycle.
`define SWR_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define SWR_ASSERT(label, prop, msg)
`define SWR_ASSERT_NEXT(label, pre, post, msg)
`endif

`endif

// File: sv/swr_pkg.sv
`timescale 1ns / 1ps

package swr_pkg;

  typedef logic signed [31:0] word_t;

  // Operation codes carried by the operation field.
  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  // Status codes returned with each result.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  // Command broadcast from the controller to every cell.
  typedef struct packed {
    logic push;     // take the word of the cell above
    logic pop;      // take the word of the cell below
    logic cmp;      // register the compare against the search key
    logic collapse; // cells at or below the first hit take the word below
  } cell_cmd_t;

  // What the cell row reports back to the controller.
  typedef struct packed {
    word_t top_word_nxt;
    logic  top_occ_nxt;
    logic  full;
    logic  empty;
    logic  hit_any;
  } row_stat_t;

endpackage

// File: sv/stack_with_value_removal_core.sv
`timescale 1ns / 1ps
// Channel | Direction | Handshake              | Beat fields
// in      | input     | in_valid_i/in_stall_o  | operation_i, data_value_i
// out     | output    | out_valid_o/out_stall_i| top_value_o, top_valid_o,
//         |           |                        | entry_count_o, status_o
// Push, pop and no-op finish when accepted; a beat can be accepted every cycle while the input does not stall.
// Remove-by-value first has every cell compare, and then, in the collapse state,
// the cells at or below the nearest hit shift toward the top.
// The result is registered and appears the cycle after the operation ends.
// Reset empties the stack at once; the input stalls only during the collapse
// cycle of a remove or while a result waits behind a stalled output.

module stack_with_value_removal_core #(
  parameter int DEPTH = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic [1:0]     operation_i,
  input  swr_pkg::word_t data_value_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output swr_pkg::word_t top_value_o,
  output logic           top_valid_o,
  output logic [6:0]     entry_count_o,
  output logic [1:0]     status_o
);
  import swr_pkg::*;

  cell_cmd_t cmd;
  row_stat_t stat;
  word_t     cell_word [DEPTH];
  logic      cell_occ  [DEPTH];
  word_t     cell_word_nxt [DEPTH];
  logic      cell_occ_nxt  [DEPTH];
  logic      hit_chain [DEPTH+1];

  assign hit_chain[0] = 1'b0;

  // Row of cells; position 0 is the top of the stack.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    word_t up_word, dn_word;
    logic  up_occ, dn_occ;

    if (i == 0) begin : g_top
      assign up_word = data_value_i;
      assign up_occ  = 1'b1;
    end else begin : g_mid_up
      assign up_word = cell_word[i-1];
      assign up_occ  = cell_occ[i-1];
    end

    if (i == DEPTH - 1) begin : g_bottom
      assign dn_word = '0;
      assign dn_occ  = 1'b0;
    end else begin : g_mid_dn
      assign dn_word = cell_word[i+1];
      assign dn_occ  = cell_occ[i+1];
    end

    swr_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmd_i      (cmd),
      .key_i      (data_value_i),
      .up_word_i  (up_word),
      .up_occ_i   (up_occ),
      .dn_word_i  (dn_word),
      .dn_occ_i   (dn_occ),
      .hit_i      (hit_chain[i]),
      .word_o     (cell_word[i]),
      .occ_o      (cell_occ[i]),
      .word_nxt_o (cell_word_nxt[i]),
      .occ_nxt_o  (cell_occ_nxt[i]),
      .hit_o      (hit_chain[i+1])
    );
  end

  // Row status seen by the controller.
  assign stat.top_word_nxt = cell_word_nxt[0];
  assign stat.top_occ_nxt  = cell_occ_nxt[0];
  assign stat.full         = cell_occ[DEPTH-1];
  assign stat.empty        = !cell_occ[0];
  assign stat.hit_any      = hit_chain[DEPTH];

  swr_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .operation_i   (operation_i),
    .cmd_o         (cmd),
    .stat_i        (stat),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .top_value_o   (top_value_o),
    .top_valid_o   (top_valid_o),
    .entry_count_o (entry_count_o),
    .status_o      (status_o)
  );

endmodule

// File: sv/swr_cell.sv
`timescale 1ns / 1ps

module swr_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  swr_pkg::cell_cmd_t cmd_i,
  input  swr_pkg::word_t    key_i,
  input  swr_pkg::word_t    up_word_i,
  input  logic              up_occ_i,
  input  swr_pkg::word_t    dn_word_i,
  input  logic              dn_occ_i,
  input  logic              hit_i,
  output swr_pkg::word_t    word_o,
  output logic              occ_o,
  output swr_pkg::word_t    word_nxt_o,
  output logic              occ_nxt_o,
  output logic              hit_o
);
  import swr_pkg::*;

  word_t word_q, word_d;
  logic  occ_q, occ_d;
  logic  hit_q, hit_d;

  // A hit here or in any cell nearer the top.
  assign hit_o = hit_i | hit_q;

  // Next word and occupancy: shift toward or away from the top, or hold.
  always_comb begin
    word_d = word_q;
    occ_d  = occ_q;
    if (cmd_i.push) begin
      word_d = up_word_i;
      occ_d  = up_occ_i;
    end else if (cmd_i.pop || (cmd_i.collapse && hit_o)) begin
      word_d = dn_word_i;
      occ_d  = dn_occ_i;
    end
  end

  // Compare result is kept for the collapse cycle that follows.
  assign hit_d = cmd_i.cmp ? (occ_q && (word_q == key_i)) : hit_q;

  assign word_o     = word_q;
  assign occ_o      = occ_q;
  assign word_nxt_o = word_d;
  assign occ_nxt_o  = occ_d;

  // Word and hit flag are payload; only occupancy is reset.
  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    hit_q  <= hit_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

endmodule

// File: sv/swr_ctrl.sv
`timescale 1ns / 1ps
`include "stack_with_value_removal_core_assert.svh"

module swr_ctrl #(
  parameter int DEPTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         operation_i,
  output swr_pkg::cell_cmd_t cmd_o,
  input  swr_pkg::row_stat_t stat_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output swr_pkg::word_t     top_value_o,
  output logic               top_valid_o,
  output logic [6:0]         entry_count_o,
  output logic [1:0]         status_o
);
  import swr_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DepthCnt = CW'(DEPTH);

  typedef enum logic {
    S_IDLE,
    S_COLLAPSE
  } state_e;

  state_e        state_q;
  logic [CW-1:0] count_q, count_d;
  logic          out_valid_q;
  word_t         top_value_q;
  logic          top_valid_q;
  logic [6:0]    entry_count_q;
  status_e       status_q, status_d;
  logic          in_accept;
  logic          finish;
  logic [CW+6:0] count_ext;

  // Accept only between searches and when the output register frees up.
  assign in_stall_o = (state_q != S_IDLE) || (out_valid_q && out_stall_i);
  assign in_accept  = in_valid_i && !in_stall_o;

  // Command to the cells and the resulting count and status.
  always_comb begin
    cmd_o    = '0;
    count_d  = count_q;
    status_d = ST_OK;
    finish   = 1'b0;
    if (state_q == S_COLLAPSE) begin
      finish = 1'b1;
      if (stat_i.hit_any) begin
        cmd_o.collapse = 1'b1;
        count_d        = count_q - CW'(1);
      end else begin
        status_d = ST_NOT_FOUND;
      end
    end else if (in_accept) begin
      finish = 1'b1;
      case (op_e'(operation_i))
        OP_PUSH: begin
          if (stat_i.full) begin
            status_d = ST_FULL;
          end else begin
            cmd_o.push = 1'b1;
            count_d    = count_q + CW'(1);
          end
        end
        OP_POP: begin
          if (stat_i.empty) begin
            status_d = ST_EMPTY;
          end else begin
            cmd_o.pop = 1'b1;
            count_d   = count_q - CW'(1);
          end
        end
        OP_REMOVE: begin
          cmd_o.cmp = 1'b1;
          finish    = 1'b0;
        end
        default: begin
          status_d = ST_OK;
        end
      endcase
    end
  end

  // Count reported in seven bits.
  assign count_ext = {7'd0, count_d};

  // State, count and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      count_q       <= '0;
      out_valid_q   <= 1'b0;
      top_value_q   <= '0;
      top_valid_q   <= 1'b0;
      entry_count_q <= '0;
      status_q      <= ST_OK;
    end else begin
      count_q <= count_d;
      if (cmd_o.cmp) begin
        state_q <= S_COLLAPSE;
      end else begin
        state_q <= S_IDLE;
      end
      if (finish) begin
        out_valid_q   <= 1'b1;
        top_value_q   <= stat_i.top_occ_nxt ? stat_i.top_word_nxt : '0;
        top_valid_q   <= stat_i.top_occ_nxt;
        entry_count_q <= count_ext[6:0];
        status_q      <= status_d;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign top_value_o   = top_value_q;
  assign top_valid_o   = top_valid_q;
  assign entry_count_o = entry_count_q;
  assign status_o      = status_q;

  `SWR_ASSERT(a_count_bound, count_q <= DepthCnt, "word count exceeds the depth")
  `SWR_ASSERT(a_count_tracks_top, (count_q != '0) == !stat_i.empty, "count disagrees with cells")
  `SWR_ASSERT(a_collapse_out_free, (state_q != S_COLLAPSE) || !out_valid_q, "output busy in collapse")
  `SWR_ASSERT_NEXT(a_search_collapses, cmd_o.cmp, state_q == S_COLLAPSE, "search without collapse")
  `SWR_ASSERT_NEXT(a_finish_result, finish, out_valid_q, "finished beat not presented")

endmodule

// File: verif/stack_with_value_removal_core_test.sv
`timescale 1ns / 1ps

module stack_with_value_removal_core_test;
  import swr_pkg::*;

  localparam int DEPTH = 64;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLDOFF_CYCLES = 90;
  localparam int POOL_SIZE = 8;

  // One stack command as offered on the input channel.
  typedef struct {
    op_e   op;
    word_t value;
  } stack_cmd_t;

  // What the stack should report after a command.
  typedef struct {
    word_t      top_value;
    logic       top_valid;
    logic [6:0] entry_count;
    status_e    status;
  } stack_view_t;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           in_valid_i = 1'b0;
  logic           in_stall_o;
  logic [1:0]     operation_i = OP_NONE;
  word_t          data_value_i = '0;
  logic           out_valid_o;
  logic           out_stall_i = 1'b0;
  word_t          top_value_o;
  logic           top_valid_o;
  logic [6:0]     entry_count_o;
  logic [1:0]     status_o;

  stack_cmd_t  pending_cmds[$];
  stack_view_t expected_views[$];

  // Shadow copy of the stack, top at index zero.
  word_t shadow_words[DEPTH];
  int    shadow_count = 0;
  int    peak_count = 0;

  word_t value_pool[POOL_SIZE];
  int    sender_idle_pct = 0;
  int    recv_stall_pct = 0;
  int    holdoff_asked = 0;
  int    holdoff_served = 0;
  int    holdoff_left = 0;
  int    mismatch_count = 0;
  int    idle_cycles = 0;
  int    op_seen[4] = '{default: 0};
  int    status_seen[4] = '{default: 0};
  int    idle_mix[4] = '{0, 58, 0, 30};
  int    stall_mix[4] = '{0, 0, 58, 30};

  wire in_fire  = in_valid_i && !in_stall_o;
  wire out_fire = out_valid_o && !out_stall_i;

  stack_with_value_removal_core #(
    .DEPTH(DEPTH)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .operation_i  (operation_i),
    .data_value_i (data_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .top_value_o  (top_value_o),
    .top_valid_o  (top_valid_o),
    .entry_count_o(entry_count_o),
    .status_o     (status_o)
  );

  always #5 clk_i = ~clk_i;

  // Apply one command to the shadow stack and return the view that follows.
  function automatic stack_view_t apply_stack_op(op_e op, word_t value);
    stack_view_t view;
    status_e     st;
    int          hit;
    st = ST_OK;
    hit = -1;
    case (op)
      OP_PUSH: begin
        if (shadow_count >= DEPTH) begin
          st = ST_FULL;
        end else begin
          for (int i = shadow_count; i > 0; i--) shadow_words[i] = shadow_words[i - 1];
          shadow_words[0] = value;
          shadow_count++;
        end
      end
      OP_POP: begin
        if (shadow_count == 0) begin
          st = ST_EMPTY;
        end else begin
          for (int i = 0; i + 1 < shadow_count; i++) shadow_words[i] = shadow_words[i + 1];
          shadow_count--;
        end
      end
      OP_REMOVE: begin
        // The occurrence nearest the top goes; everything below moves up.
        for (int i = 0; i < shadow_count; i++) begin
          if (hit < 0 && shadow_words[i] == value) hit = i;
        end
        if (hit < 0) begin
          st = ST_NOT_FOUND;
        end else begin
          for (int i = hit; i + 1 < shadow_count; i++) shadow_words[i] = shadow_words[i + 1];
          shadow_count--;
        end
      end
      default: begin
      end
    endcase
    if (shadow_count > peak_count) peak_count = shadow_count;
    op_seen[op]++;
    status_seen[st]++;
    view.top_value   = (shadow_count > 0) ? shadow_words[0] : '0;
    view.top_valid   = (shadow_count > 0);
    view.entry_count = shadow_count[6:0];
    view.status      = st;
    return view;
  endfunction

  // Mostly words from a small pool so that removes find matches at any depth.
  function automatic word_t pick_value();
    if ($urandom_range(99) < 65) return value_pool[$urandom_range(POOL_SIZE - 1)];
    return word_t'($urandom);
  endfunction

  function automatic stack_cmd_t random_cmd(int push_pct);
    stack_cmd_t cmd;
    int         roll;
    roll = $urandom_range(99);
    if (roll < 3) cmd.op = OP_NONE;
    else if (roll < 3 + push_pct * 97 / 100) cmd.op = OP_PUSH;
    else if ($urandom_range(1) == 1) cmd.op = OP_POP;
    else cmd.op = OP_REMOVE;
    cmd.value = pick_value();
    return cmd;
  endfunction

  task automatic add_cmd(op_e op, word_t value);
    stack_cmd_t cmd;
    cmd.op = op;
    cmd.value = value;
    pending_cmds.insert(pending_cmds.size(), cmd);
  endtask

  // Segments that lean toward growth, stay balanced or lean toward draining, random content.
  task automatic queue_random_cmds(int total);
    int seg_len;
    int push_pct;
    int pick;
    while (total > 0) begin
      seg_len = $urandom_range(10, 60);
      pick = $urandom_range(2);
      push_pct = (pick == 0) ? 85 : ((pick == 1) ? 50 : 20);
      for (int i = 0; i < seg_len && total > 0; i++) begin
        pending_cmds.insert(pending_cmds.size(), random_cmd(push_pct));
        total--;
      end
    end
  endtask

  // Wait until every queued beat went in and every result came back.
  task automatic wait_drained();
    while (pending_cmds.size() > 0 || in_valid_i || expected_views.size() > 0) begin
      @(negedge clk_i);
    end
  endtask

  // Driver: present the next queued command, hold it while stalled.
  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    stack_cmd_t next_cmd;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_fire) begin
        expected_views.insert(expected_views.size(),
                              apply_stack_op(op_e'(operation_i), data_value_i));
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (pending_cmds.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          next_cmd = pending_cmds.pop_front();
          in_valid_i   <= 1'b1;
          operation_i  <= next_cmd.op;
          data_value_i <= next_cmd.value;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result beat and drive the output stall.
  always @(posedge clk_i or negedge rst_ni) begin : check_proc
    stack_view_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_fire) begin
        if (expected_views.size() == 0) begin
          $error("result beat with no command outstanding");
          mismatch_count++;
        end else begin
          want = expected_views.pop_front();
          if (top_value_o !== want.top_value) begin
            $error("top_value expected %0d got %0d", want.top_value, top_value_o);
            mismatch_count++;
          end
          if (top_valid_o !== want.top_valid) begin
            $error("top_valid expected %0d got %0d", want.top_valid, top_valid_o);
            mismatch_count++;
          end
          if (entry_count_o !== want.entry_count) begin
            $error("entry_count expected %0d got %0d", want.entry_count, entry_count_o);
            mismatch_count++;
          end
          if (status_o !== want.status) begin
            $error("status expected %0d got %0d", want.status, status_o);
            mismatch_count++;
          end
        end
      end
      // A long hold-off lets the stack back up into its input.
      if (holdoff_served != holdoff_asked) begin
        holdoff_served = holdoff_asked;
        holdoff_left = HOLDOFF_CYCLES;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a beat.
  always @(posedge clk_i) begin
    if (!rst_ni || in_fire || out_fire) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    value_pool[0] = word_t'(32'h8000_0000);
    value_pool[1] = word_t'(32'h7FFF_FFFF);
    value_pool[2] = '0;
    value_pool[3] = word_t'(32'hFFFF_FFFF);
    for (int i = 4; i < POOL_SIZE; i++) value_pool[i] = word_t'($urandom);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty-stack corners, extremes, duplicates, deep and missing removes.
    add_cmd(OP_POP, '0);
    add_cmd(OP_REMOVE, 32'sd7);
    add_cmd(OP_NONE, '0);
    add_cmd(OP_PUSH, word_t'(32'h8000_0000));
    add_cmd(OP_PUSH, word_t'(32'h7FFF_FFFF));
    add_cmd(OP_PUSH, '0);
    add_cmd(OP_PUSH, word_t'(32'hFFFF_FFFF));
    add_cmd(OP_PUSH, 32'sd5);
    add_cmd(OP_PUSH, 32'sd5);
    add_cmd(OP_REMOVE, 32'sd5);
    add_cmd(OP_NONE, word_t'(32'hFFFF_FFFF));
    add_cmd(OP_REMOVE, word_t'(32'h8000_0000));
    add_cmd(OP_REMOVE, 32'sd1234);
    add_cmd(OP_PUSH, word_t'(32'hAAAA_AAAA));
    add_cmd(OP_PUSH, word_t'(32'h5555_5555));
    add_cmd(OP_REMOVE, word_t'(32'hAAAA_AAAA));
    add_cmd(OP_POP, '0);
    add_cmd(OP_POP, '0);
    add_cmd(OP_POP, '0);
    add_cmd(OP_POP, '0);
    add_cmd(OP_POP, '0);
    add_cmd(OP_REMOVE, '0);
    wait_drained();

    // Random phases under the four idling mixes, draining in between.
    for (int phase = 0; phase < 4; phase++) begin
      sender_idle_pct = idle_mix[phase];
      recv_stall_pct = stall_mix[phase];
      if (phase == 0) begin
        // Fill to the brim, then keep pushing against a full stack.
        for (int i = 0; i < DEPTH + 4; i++) add_cmd(OP_PUSH, pick_value());
        holdoff_asked++;
      end
      queue_random_cmds(140);
      wait_drained();
    end

    repeat (10) @(posedge clk_i);
    $display("Ran %0d commands: %0d push, %0d pop, %0d remove, %0d no-op; peak depth %0d.",
             op_seen[OP_PUSH] + op_seen[OP_POP] + op_seen[OP_REMOVE] + op_seen[OP_NONE],
             op_seen[OP_PUSH], op_seen[OP_POP], op_seen[OP_REMOVE], op_seen[OP_NONE],
             peak_count);
    $display("Full drops %0d, empty pops %0d, removes with no match %0d, under four stall mixes.",
             status_seen[ST_FULL], status_seen[ST_EMPTY], status_seen[ST_NOT_FOUND]);
    if (mismatch_count == 0 && expected_views.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
